FILE: hdl/cis_pkg.sv
// Package for the coalescing interval set: operation codes and field widths.
// Used by the channel interfaces and by the top level. No dependencies.
package cis_pkg;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned INPOS_W = 32;
	localparam int unsigned PCNT_W  = 33;
	localparam int unsigned ICNT_W  = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
endpackage

FILE: hdl/cis_if.sv
// Request and response channel interfaces of the coalescing interval set.
// Depends on cis_pkg for the field widths.
interface cis_req_if;
	logic                        valid;
	logic                        ready;
	logic [cis_pkg::OP_W-1:0]    operation;
	logic [cis_pkg::INPOS_W-1:0] position;
	modport source (output valid, output operation, output position, input ready);
	modport sink (input valid, input operation, input position, output ready);
endinterface

interface cis_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic                       table_full;
	logic [cis_pkg::PCNT_W-1:0] position_count;
	logic [cis_pkg::ICNT_W-1:0] interval_count;
	modport source (output valid, output hit, output table_full, output position_count,
		output interval_count, input ready);
	modport sink (input valid, input hit, input table_full, input position_count,
		input interval_count, output ready);
endinterface

FILE: hdl/cis_table_mem.sv
// Interval table storage: one write port and one read port with registered read data.
// Standalone; instantiated by coalescing_interval_set_core.
module cis_table_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/coalescing_interval_set_core.sv
// Top level of the coalescing interval set: sequencer that scans, merges and shifts
// the sorted interval table. Depends on cis_pkg, cis_if.sv and cis_table_mem.
//
//  channel | role | contents
//  req     | sink | operation, position
//  rsp     | src  | hit, table_full, position_count, interval_count
//
// A find or insert scans one table entry per cycle through the single read port, from
// entry 0 up to the located entry k. An insert that opens a new interval or merges two
// intervals then moves every later entry once, one per cycle. Reset clears the counts
// and the control state; the table needs no clearing. A stalled response holds the
// finished result and the next request waits behind it.
module coalescing_interval_set_core #(
	parameter int unsigned MAX_INTERVALS = 64,
	parameter int unsigned POS_WIDTH     = 32
) (
	input  logic clk,
	input  logic arst_n,
	cis_req_if.sink   req,
	cis_rsp_if.source rsp
);
	localparam int unsigned AW = $clog2(MAX_INTERVALS);
	localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
	localparam int unsigned EW = 2 * POS_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_SHDN = 3'd2;
	localparam logic [2:0] ST_SHUP = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]                 state_q;
	logic [cis_pkg::OP_W-1:0]   op_q;
	logic [POS_WIDTH-1:0]       p_q;
	logic [CW-1:0]              k_q;
	logic [CW-1:0]              j_q;
	logic [POS_WIDTH-1:0]       prev_start_q;
	logic [POS_WIDTH-1:0]       prev_end_q;
	logic [CW-1:0]              used_q;
	logic [cis_pkg::PCNT_W-1:0] held_q;
	logic                       hit_q;
	logic                       full_q;
	logic                       rsp_valid_q;
	logic                       rsp_hit_q;
	logic                       rsp_full_q;
	logic [cis_pkg::PCNT_W-1:0] rsp_pcnt_q;
	logic [cis_pkg::ICNT_W-1:0] rsp_icnt_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [EW-1:0]        wdata;
	logic [AW-1:0]        raddr;
	logic [EW-1:0]        rdata;
	logic [POS_WIDTH-1:0] cur_start;
	logic [POS_WIDTH-1:0] cur_end;
	logic [POS_WIDTH-1:0] in_pos;
	logic [63:0]          in_pos64;
	logic [63:0]          used64;
	logic [CW-1:0]        k_inc;
	logic [CW-1:0]        k_dec;
	logic [CW-1:0]        j_inc;
	logic [CW-1:0]        j_dec;
	logic [CW-1:0]        used_dec;
	logic                 in_range;
	logic                 advance;
	logic                 present;
	logic                 left;
	logic                 right;
	logic                 fin_go;

	cis_table_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(EW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign in_pos64  = 64'(req.position);
	assign in_pos    = in_pos64[POS_WIDTH-1:0];
	assign used64    = 64'(used_q);
	assign cur_start = rdata[EW-1:POS_WIDTH];
	assign cur_end   = rdata[POS_WIDTH-1:0];
	assign k_inc     = k_q + 1'b1;
	assign k_dec     = k_q - 1'b1;
	assign j_inc     = j_q + 1'b1;
	assign j_dec     = j_q - 1'b1;
	assign used_dec  = used_q - 1'b1;
	assign in_range  = (k_q < used_q);
	assign advance   = in_range && (cur_end < p_q);
	assign present   = in_range && (cur_start <= p_q);
	assign left      = (k_q != '0) && (({1'b0, prev_end_q} + 1'b1) == {1'b0, p_q});
	assign right     = in_range && ({1'b0, cur_start} == ({1'b0, p_q} + 1'b1));
	assign fin_go    = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (state_q)
			ST_SCAN: begin
				if (advance) begin
					raddr = k_inc[AW-1:0];
				end else if (op_q == cis_pkg::OP_INSERT && !present) begin
					if (left && right) begin
						we    = 1'b1;
						waddr = k_dec[AW-1:0];
						wdata = {prev_start_q, cur_end};
						raddr = k_inc[AW-1:0];
					end else if (left) begin
						we    = 1'b1;
						waddr = k_dec[AW-1:0];
						wdata = {prev_start_q, p_q};
					end else if (right) begin
						we    = 1'b1;
						waddr = k_q[AW-1:0];
						wdata = {p_q, cur_end};
					end else begin
						raddr = used_dec[AW-1:0];
					end
				end
			end
			ST_SHDN: begin
				if (j_q < used_q) begin
					we    = 1'b1;
					waddr = j_dec[AW-1:0];
					wdata = rdata;
					raddr = j_inc[AW-1:0];
				end
			end
			ST_SHUP: begin
				we    = 1'b1;
				waddr = j_inc[AW-1:0];
				wdata = rdata;
				raddr = j_dec[AW-1:0];
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = k_q[AW-1:0];
				wdata = {p_q, p_q};
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			op_q        <= cis_pkg::OP_INSERT;
			k_q         <= '0;
			j_q         <= '0;
		end else begin
			if (state_q == ST_FIN && fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q   <= req.operation;
						p_q    <= in_pos;
						k_q    <= '0;
						hit_q  <= 1'b0;
						full_q <= 1'b0;
						if (req.operation == cis_pkg::OP_INSERT
							|| req.operation == cis_pkg::OP_FIND) begin
							state_q <= ST_SCAN;
						end else begin
							if (req.operation == cis_pkg::OP_CLEAR) begin
								used_q <= '0;
								held_q <= '0;
							end
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (advance) begin
						prev_start_q <= cur_start;
						prev_end_q   <= cur_end;
						k_q          <= k_inc;
					end else if (op_q != cis_pkg::OP_INSERT) begin
						hit_q   <= present;
						state_q <= ST_FIN;
					end else if (present) begin
						state_q <= ST_FIN;
					end else if (left || right) begin
						hit_q  <= 1'b1;
						held_q <= held_q + 1'b1;
						if (left && right) begin
							j_q     <= k_inc;
							state_q <= ST_SHDN;
						end else begin
							state_q <= ST_FIN;
						end
					end else if (used_q == CW'(MAX_INTERVALS)) begin
						full_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						hit_q  <= 1'b1;
						held_q <= held_q + 1'b1;
						if (k_q == used_q) begin
							state_q <= ST_PUT;
						end else begin
							j_q     <= used_dec;
							state_q <= ST_SHUP;
						end
					end
				end
				ST_SHDN: begin
					if (j_q < used_q) begin
						j_q <= j_inc;
					end else begin
						used_q  <= used_dec;
						state_q <= ST_FIN;
					end
				end
				ST_SHUP: begin
					if (j_q == k_q) begin
						state_q <= ST_PUT;
					end else begin
						j_q <= j_dec;
					end
				end
				ST_PUT: begin
					used_q  <= used_q + 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && fin_go) begin
			rsp_hit_q  <= hit_q;
			rsp_full_q <= full_q;
			rsp_pcnt_q <= held_q;
			rsp_icnt_q <= used64[cis_pkg::ICNT_W-1:0];
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = rsp_hit_q;
	assign rsp.table_full     = rsp_full_q;
	assign rsp.position_count = rsp_pcnt_q;
	assign rsp.interval_count = rsp_icnt_q;
endmodule

FILE: tb/tb_coalescing_interval_set_core.sv
// Testbench for the coalescing interval set: directed and random requests through
// the request and response interfaces, checked against a behavioral interval table.
// Depends on cis_pkg, cis_if.sv and the coalescing_interval_set_core RTL.
`timescale 1ns / 1ps

module tb_coalescing_interval_set_core;
	localparam int unsigned SLOTS = 64;
	localparam logic [cis_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [cis_pkg::OP_W-1:0]    operation;
		logic [cis_pkg::INPOS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic                       hit;
		logic                       table_full;
		logic [cis_pkg::PCNT_W-1:0] position_count;
		logic [cis_pkg::ICNT_W-1:0] interval_count;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cis_req_if req ();
	cis_rsp_if rsp ();

	coalescing_interval_set_core #(.MAX_INTERVALS(SLOTS), .POS_WIDTH(32)) uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	logic [31:0] span_lo [SLOTS];
	logic [31:0] span_hi [SLOTS];
	int          span_cnt = 0;
	logic [32:0] seen_cnt = '0;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   send_idle_pct = 17;
	int   recv_idle_pct = 53;
	bit   hold_start = 0;
	bit   hold_taken;
	int   hold_cnt;
	int   mismatches = 0;

	function automatic rsp_t predict_interval_set(req_t r);
		rsp_t o;
		int k;
		logic [32:0] p;
		bit lft, rgt;
		o = '0;
		p = {1'b0, r.position};
		k = 0;
		if (r.operation == cis_pkg::OP_INSERT || r.operation == cis_pkg::OP_FIND) begin
			while (k < span_cnt && {1'b0, span_hi[k]} < p) k++;
		end
		if (r.operation == cis_pkg::OP_INSERT) begin
			if (!(k < span_cnt && {1'b0, span_lo[k]} <= p)) begin
				lft = (k > 0) && ({1'b0, span_hi[k-1]} + 33'd1 == p);
				rgt = (k < span_cnt) && ({1'b0, span_lo[k]} == p + 33'd1);
				if (lft && rgt) begin
					span_hi[k-1] = span_hi[k];
					for (int i = k; i < span_cnt - 1; i++) begin
						span_lo[i] = span_lo[i+1];
						span_hi[i] = span_hi[i+1];
					end
					span_cnt--;
					o.hit = 1;
				end else if (lft) begin
					span_hi[k-1] = r.position;
					o.hit = 1;
				end else if (rgt) begin
					span_lo[k] = r.position;
					o.hit = 1;
				end else if (span_cnt >= SLOTS) begin
					o.table_full = 1;
				end else begin
					for (int i = span_cnt; i > k; i--) begin
						span_lo[i] = span_lo[i-1];
						span_hi[i] = span_hi[i-1];
					end
					span_lo[k] = r.position;
					span_hi[k] = r.position;
					span_cnt++;
					o.hit = 1;
				end
				if (o.hit) seen_cnt++;
			end
		end else if (r.operation == cis_pkg::OP_FIND) begin
			o.hit = (k < span_cnt && {1'b0, span_lo[k]} <= p);
		end else if (r.operation == cis_pkg::OP_CLEAR) begin
			span_cnt = 0;
			seen_cnt = '0;
		end
		o.position_count = seen_cnt;
		o.interval_count = span_cnt[cis_pkg::ICNT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		req_t nx;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= cis_pkg::OP_INSERT;
			req.position <= '0;
		end else begin
			if (req.valid && req.ready) begin
				nx = req_t'({req.operation, req.position});
				expected_rsps.push_back(predict_interval_set(nx));
			end
			if (!req.valid || req.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nx = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.operation <= nx.operation;
					req.position <= nx.position;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_taken <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_start && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cnt <= 400;
			rsp.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t got, exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp_t'({rsp.hit, rsp.table_full, rsp.position_count, rsp.interval_count});
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", got);
			end else begin
				exp_r = expected_rsps.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
	end

	task automatic add_req(logic [cis_pkg::OP_W-1:0] op, logic [31:0] pos);
		req_t r;
		r.operation = op;
		r.position = pos;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_random(int n);
		logic [31:0] base;
		int sel;
		base = $urandom;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 55) add_req(cis_pkg::OP_INSERT, base + $urandom_range(300));
			else if (sel < 85) add_req(cis_pkg::OP_FIND, base + $urandom_range(300));
			else if (sel < 88) add_req(cis_pkg::OP_CLEAR, $urandom);
			else if (sel < 90) add_req(OP_UNUSED, $urandom);
			else if (sel < 95) add_req(cis_pkg::OP_INSERT, $urandom);
			else add_req(cis_pkg::OP_FIND, $urandom);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_req(cis_pkg::OP_FIND, 32'd0);
		add_req(cis_pkg::OP_INSERT, 32'd0);
		add_req(cis_pkg::OP_INSERT, 32'd0);
		add_req(cis_pkg::OP_INSERT, 32'hFFFF_FFFF);
		add_req(cis_pkg::OP_INSERT, 32'hFFFF_FFFE);
		add_req(cis_pkg::OP_INSERT, 32'd2);
		add_req(cis_pkg::OP_INSERT, 32'd1);
		add_req(cis_pkg::OP_INSERT, 32'd5);
		add_req(cis_pkg::OP_INSERT, 32'd4);
		add_req(cis_pkg::OP_FIND, 32'd3);
		add_req(cis_pkg::OP_FIND, 32'hFFFF_FFFE);
		add_req(OP_UNUSED, 32'hAAAA_5555);
		add_req(cis_pkg::OP_CLEAR, 32'h5555_AAAA);
		add_req(cis_pkg::OP_FIND, 32'd1);
		drain();
		for (int i = 0; i < SLOTS; i++) add_req(cis_pkg::OP_INSERT, 32'd10 * i);
		add_req(cis_pkg::OP_INSERT, 32'd1000);
		add_req(cis_pkg::OP_INSERT, 32'd11);
		add_req(cis_pkg::OP_INSERT, 32'd19);
		add_req(cis_pkg::OP_INSERT, 32'd12);
		add_req(cis_pkg::OP_FIND, 32'd12);
		add_req(cis_pkg::OP_CLEAR, 32'd0);
		drain();
		add_random(120);
		drain();
		send_idle_pct = 53;
		recv_idle_pct = 17;
		hold_start = 1;
		add_random(120);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(120);
		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("** coalescing_interval_set_core: PASSED **");
		end else begin
			$display("** coalescing_interval_set_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("** coalescing_interval_set_core: FAILED **");
		$finish;
	end
endmodule
